@@ rtl/core/mwm_pkg.sv @@
// Package for the mecanum wheel mixer: widths, command constants and the
// RC byte to signed command mapping. No dependencies.
package mwm_pkg;

  // Field widths
  localparam int BYTE_W  = 8;
  localparam int CMD_W   = 8;   // signed command, -127..127
  localparam int SUM_W   = 10;  // signed wheel sum, -381..381
  localparam int MAG_W   = 9;   // |sum|, 0..381
  localparam int PROD_W  = 17;  // |sum| * max_speed, up to 97155
  localparam int PULSE_W = 8;

  // Number of wheels and divider stages (one quotient bit per stage)
  localparam int NUM_WHEELS = 4;
  localparam int DIV_STAGES = PULSE_W;

  // Wheel slots
  localparam int W_FR = 0;
  localparam int W_FL = 1;
  localparam int W_RR = 2;
  localparam int W_RL = 3;

  // Command constants
  localparam logic [BYTE_W-1:0] DEADBAND_LO = 8'd124;
  localparam logic [BYTE_W-1:0] DEADBAND_HI = 8'd130;
  localparam logic [BYTE_W-1:0] CMD_FULL    = 8'd127;
  localparam logic [BYTE_W-1:0] MAX_SPEED_RST = 8'd255;

  typedef logic signed [CMD_W-1:0] cmd_t;
  typedef logic [MAG_W-1:0]        mag_t;
  typedef logic [PROD_W-1:0]       prod_t;

  // One wheel's partial result inside the divider pipeline
  typedef struct packed {
    prod_t               rem;
    logic [PULSE_W-1:0]  quo;
  } div_lane_t;

  // Deadband, offset and clamp of one RC byte
  function automatic cmd_t byte_to_cmd(input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] v;
    logic signed [BYTE_W+1:0] c;
    begin
      v = b;
      if (b > DEADBAND_LO && b < DEADBAND_HI) begin
        v = CMD_FULL;
      end
      c = $signed({2'b00, v}) - $signed({2'b00, CMD_FULL});
      // only byte 255 overshoots (+128)
      if (c > $signed({2'b00, CMD_FULL})) begin
        c = $signed({2'b00, CMD_FULL});
      end
      byte_to_cmd = c[CMD_W-1:0];
    end
  endfunction

endpackage

@@ rtl/core/mecanum_wheel_mixer.sv @@
// Mecanum wheel mixer top level: command mapping, wheel sums, scaling and a
// pipelined restoring divider. Depends on mwm_pkg.
// Pipeline: 3 front stages plus 8 divider stages, one quotient bit each; out_valid and
// the results come straight from the last divider register. Throughput: one transaction
// per cycle while busy is low; the receiver cannot stall. Reset: synchronous, active low;
// clears all valid bits, sets max_speed to 255; busy drops in the cycle after reset ends.
module mecanum_wheel_mixer
  import mwm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // configuration
  input  logic               cfg_wr_en,
  input  logic [BYTE_W-1:0]  cfg_wr_data,
  // command channel
  input  logic               start,
  output logic               busy,
  input  logic [BYTE_W-1:0]  in_drive_byte,
  input  logic [BYTE_W-1:0]  in_turn_byte,
  input  logic [BYTE_W-1:0]  in_strafe_byte,
  // result channel
  output logic               out_valid,
  output logic [PULSE_W-1:0] out_pulse_front_right,
  output logic [PULSE_W-1:0] out_pulse_front_left,
  output logic [PULSE_W-1:0] out_pulse_rear_right,
  output logic [PULSE_W-1:0] out_pulse_rear_left,
  output logic               out_dir_front_right,
  output logic               out_dir_front_left,
  output logic               out_dir_rear_right,
  output logic               out_dir_rear_left
);

  logic                accept;
  logic                busy_r;
  logic [BYTE_W-1:0]   max_speed_r;

  // stage 1: commands
  logic                v1_r;
  cmd_t                cmd_d_r, cmd_t_r, cmd_s_r;

  // stage 2: magnitudes and directions
  logic signed [SUM_W-1:0] sum_nxt [NUM_WHEELS];
  logic                v2_r;
  mag_t                mag_r [NUM_WHEELS];
  logic [NUM_WHEELS-1:0] dir2_r;

  // stage 3: products and divisor
  mag_t                max01, max23, maxmag;
  mag_t                den_nxt;
  logic                v3_r;
  prod_t               prod_r [NUM_WHEELS];
  mag_t                den3_r;
  logic [NUM_WHEELS-1:0] dir3_r;

  // divider pipeline
  div_lane_t           lane_src [DIV_STAGES][NUM_WHEELS];
  mag_t                den_src  [DIV_STAGES];
  logic [NUM_WHEELS-1:0] dir_src [DIV_STAGES];
  logic                vld_src  [DIV_STAGES];
  div_lane_t           lane_nxt [DIV_STAGES][NUM_WHEELS];
  div_lane_t           lane_r   [DIV_STAGES][NUM_WHEELS];
  mag_t                den_r    [DIV_STAGES];
  logic [NUM_WHEELS-1:0] dir_r  [DIV_STAGES];
  logic                vld_r    [DIV_STAGES];

  assign accept = start && !busy_r;
  assign busy   = busy_r;

  // busy only while in reset
  always_ff @(posedge clk) begin
    busy_r <= !rst_n;
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_speed_r <= MAX_SPEED_RST;
    end else if (cfg_wr_en) begin
      max_speed_r <= cfg_wr_data;
    end
  end

  // valid chain of the front stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= accept;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // stage 1: deadband and clamp
  always_ff @(posedge clk) begin
    cmd_d_r <= byte_to_cmd(in_drive_byte);
    cmd_t_r <= byte_to_cmd(in_turn_byte);
    cmd_s_r <= byte_to_cmd(in_strafe_byte);
  end

  // stage 2: wheel sums
  always_comb begin
    sum_nxt[W_FR] = SUM_W'(cmd_d_r) + SUM_W'(cmd_t_r) + SUM_W'(cmd_s_r);
    sum_nxt[W_FL] = SUM_W'(cmd_d_r) - SUM_W'(cmd_t_r) - SUM_W'(cmd_s_r);
    sum_nxt[W_RR] = SUM_W'(cmd_d_r) + SUM_W'(cmd_t_r) - SUM_W'(cmd_s_r);
    sum_nxt[W_RL] = SUM_W'(cmd_d_r) - SUM_W'(cmd_t_r) + SUM_W'(cmd_s_r);
  end

  always_ff @(posedge clk) begin
    for (int w = 0; w < NUM_WHEELS; w++) begin
      mag_r[w] <= sum_nxt[w][SUM_W-1] ? MAG_W'(-sum_nxt[w]) : MAG_W'(sum_nxt[w]);
    end
    // left wheels are mounted mirrored
    dir2_r[W_FR] <= (sum_nxt[W_FR] > 0);
    dir2_r[W_FL] <= !(sum_nxt[W_FL] > 0);
    dir2_r[W_RR] <= (sum_nxt[W_RR] > 0);
    dir2_r[W_RL] <= !(sum_nxt[W_RL] > 0);
  end

  // stage 3: largest magnitude above 127 picks the divisor, else 127 (also at zero max_speed); scale by max_speed
  always_comb begin
    max01   = (mag_r[0] > mag_r[1]) ? mag_r[0] : mag_r[1];
    max23   = (mag_r[2] > mag_r[3]) ? mag_r[2] : mag_r[3];
    maxmag  = (max01 > max23) ? max01 : max23;
    den_nxt = MAG_W'(CMD_FULL);
    if (max_speed_r != '0 && maxmag > MAG_W'(CMD_FULL)) begin
      den_nxt = maxmag;
    end
  end

  always_ff @(posedge clk) begin
    for (int w = 0; w < NUM_WHEELS; w++) begin
      prod_r[w] <= PROD_W'(mag_r[w]) * PROD_W'(max_speed_r);
    end
    den3_r <= den_nxt;
    dir3_r <= dir2_r;
  end

  // divider: stage k decides quotient bit DIV_STAGES-1-k
  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    localparam int SH = DIV_STAGES - 1 - g;
    prod_t trial;

    if (g == 0) begin : g_first
      always_comb begin
        for (int w = 0; w < NUM_WHEELS; w++) begin
          lane_src[g][w].rem = prod_r[w];
          lane_src[g][w].quo = '0;
        end
        den_src[g] = den3_r;
        dir_src[g] = dir3_r;
        vld_src[g] = v3_r;
      end
    end else begin : g_next
      always_comb begin
        for (int w = 0; w < NUM_WHEELS; w++) begin
          lane_src[g][w] = lane_r[g-1][w];
        end
        den_src[g] = den_r[g-1];
        dir_src[g] = dir_r[g-1];
        vld_src[g] = vld_r[g-1];
      end
    end

    assign trial = PROD_W'(den_src[g]) << SH;

    // compare and subtract per wheel
    always_comb begin
      for (int w = 0; w < NUM_WHEELS; w++) begin
        lane_nxt[g][w] = lane_src[g][w];
        if (lane_src[g][w].rem >= trial) begin
          lane_nxt[g][w].rem     = lane_src[g][w].rem - trial;
          lane_nxt[g][w].quo[SH] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else begin
        vld_r[g] <= vld_src[g];
      end
    end

    always_ff @(posedge clk) begin
      for (int w = 0; w < NUM_WHEELS; w++) begin
        lane_r[g][w] <= lane_nxt[g][w];
      end
      den_r[g] <= den_src[g];
      dir_r[g] <= dir_src[g];
    end
  end

  // outputs straight from the last divider stage
  assign out_valid             = vld_r[DIV_STAGES-1];
  assign out_pulse_front_right = lane_r[DIV_STAGES-1][W_FR].quo;
  assign out_pulse_front_left  = lane_r[DIV_STAGES-1][W_FL].quo;
  assign out_pulse_rear_right  = lane_r[DIV_STAGES-1][W_RR].quo;
  assign out_pulse_rear_left   = lane_r[DIV_STAGES-1][W_RL].quo;
  assign out_dir_front_right   = dir_r[DIV_STAGES-1][W_FR];
  assign out_dir_front_left    = dir_r[DIV_STAGES-1][W_FL];
  assign out_dir_rear_right    = dir_r[DIV_STAGES-1][W_RR];
  assign out_dir_rear_left     = dir_r[DIV_STAGES-1][W_RL];

`ifndef SYNTHESIS
  // once out of reset the block always takes a transaction
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !busy)
    else $error("busy high outside reset");

  // every result traces back to an accepted transaction
  a_result_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, DIV_STAGES + 3))
    else $error("result without a matching transaction");

  // divisor stays in the range the 8-bit quotient relies on
  a_den_range: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r |-> (den3_r >= MAG_W'(CMD_FULL) && den3_r <= MAG_W'(381)))
    else $error("divisor out of range");

  // the divider leaves the front right remainder below the divisor
  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (lane_r[DIV_STAGES-1][W_FR].rem < PROD_W'(den_r[DIV_STAGES-1])))
    else $error("divider remainder not reduced");

  // zero speed gives zero pulses
  a_zero_speed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && max_speed_r == '0) |->
      (out_pulse_front_right == '0 && out_pulse_front_left == '0 &&
       out_pulse_rear_right == '0 && out_pulse_rear_left == '0))
    else $error("nonzero pulse at zero speed");
`endif

endmodule
